// ----- rtl/ezyx_pkg.sv -----
package ezyx_pkg;

  // field widths
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned TRIG_STAGES_DEF = 16;

  // internal Q.30 arithmetic
  localparam int unsigned FRAC = 30;
  localparam int unsigned XYW  = 34;  // CORDIC datapath
  localparam int unsigned TW   = 32;  // sine / cosine, |v| <= ~1.0
  localparam int unsigned SW   = TW + 1;  // sum of two products
  localparam int unsigned ANGLE_SHIFT = FRAC - (ANGLE_W - 3);
  localparam int unsigned ELEM_FRAC = ELEM_W - 2;
  localparam int unsigned ELEM_SHIFT = FRAC - ELEM_FRAC;

  localparam logic signed [XYW-1:0] PI30      = 34'sd3373259426;
  localparam logic signed [XYW-1:0] HALF_PI30 = 34'sd1686629713;
  localparam logic signed [XYW-1:0] GAIN30    = 34'sd652032874;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
  } ezyx_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_00;
    logic signed [ELEM_W-1:0] elem_01;
    logic signed [ELEM_W-1:0] elem_02;
    logic signed [ELEM_W-1:0] elem_10;
    logic signed [ELEM_W-1:0] elem_11;
    logic signed [ELEM_W-1:0] elem_12;
    logic signed [ELEM_W-1:0] elem_20;
    logic signed [ELEM_W-1:0] elem_21;
    logic signed [ELEM_W-1:0] elem_22;
  } ezyx_out_t;

  // atan(2^-i) in Q.30, truncated
  function automatic logic signed [XYW-1:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return signed'({{(XYW-32){1'b0}}, v});
  endfunction

  // Q.30 product, rounded half up
  function automatic logic signed [TW-1:0] mul30(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = (a * b) + (2*TW)'(64'sd1 <<< (FRAC - 1));
    return TW'(p >>> FRAC);
  endfunction

  // round to output format and clip to +/-1.0
  function automatic logic signed [ELEM_W-1:0] to_elem(input logic signed [SW-1:0] v);
    logic signed [SW:0] t;
    logic signed [SW:0] lim;
    t   = (SW+1)'(v) + (SW+1)'(64'sd1 <<< (ELEM_SHIFT - 1));
    t   = t >>> ELEM_SHIFT;
    lim = (SW+1)'(64'sd1 <<< ELEM_FRAC);
    if (t > lim) begin
      t = lim;
    end else if (t < -lim) begin
      t = -lim;
    end
    return ELEM_W'(t);
  endfunction

endpackage

// ----- rtl/ezyx_trig.sv -----
module ezyx_trig #(
  parameter int unsigned TRIG_STAGES = ezyx_pkg::TRIG_STAGES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [ezyx_pkg::ANGLE_W-1:0]  angle_i,
  output logic signed [ezyx_pkg::TW-1:0]       sin_o,
  output logic signed [ezyx_pkg::TW-1:0]       cos_o
);
  import ezyx_pkg::*;

  logic signed [XYW-1:0] x_q [0:TRIG_STAGES];
  logic signed [XYW-1:0] y_q [0:TRIG_STAGES];
  logic signed [XYW-1:0] z_q [0:TRIG_STAGES];
  logic                  neg_q [0:TRIG_STAGES];
  logic signed [XYW-1:0] a, z0_d;
  logic                  neg_d;
  logic signed [TW-1:0]  sin_q, cos_q;

  // reduce by pi into the convergence range
  always_comb begin
    a = XYW'(angle_i) <<< ANGLE_SHIFT;
    if (a > HALF_PI30) begin
      z0_d  = a - PI30;
      neg_d = 1'b1;
    end else if (a < -HALF_PI30) begin
      z0_d  = a + PI30;
      neg_d = 1'b1;
    end else begin
      z0_d  = a;
      neg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= GAIN30;
      y_q[0]   <= '0;
      z_q[0]   <= z0_d;
      neg_q[0] <= neg_d;
    end
  end

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    localparam logic signed [XYW-1:0] Atan = atan_q30(i);
    logic signed [XYW-1:0] x_d, y_d, z_d;
    always_comb begin
      if (z_q[i] >= 0) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - Atan;
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + Atan;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]   <= x_d;
        y_q[i+1]   <= y_d;
        z_q[i+1]   <= z_d;
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= neg_q[TRIG_STAGES] ? TW'(-y_q[TRIG_STAGES]) : TW'(y_q[TRIG_STAGES]);
      cos_q <= neg_q[TRIG_STAGES] ? TW'(-x_q[TRIG_STAGES]) : TW'(x_q[TRIG_STAGES]);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- rtl/ezyx_matrix.sv -----
module ezyx_matrix (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [ezyx_pkg::TW-1:0] sr_i,
  input  logic signed [ezyx_pkg::TW-1:0] cr_i,
  input  logic signed [ezyx_pkg::TW-1:0] sp_i,
  input  logic signed [ezyx_pkg::TW-1:0] cp_i,
  input  logic signed [ezyx_pkg::TW-1:0] sy_i,
  input  logic signed [ezyx_pkg::TW-1:0] cy_i,
  output ezyx_pkg::ezyx_out_t            mat_o
);
  import ezyx_pkg::*;

  // first products
  logic signed [TW-1:0] cysp_q, sysp_q, cycp_q, sycp_q, sycr_q, sysr_q;
  logic signed [TW-1:0] cycr_q, cysr_q, cpsr_q, cpcr_q, sr_q, cr_q;
  logic signed [SW-1:0] msp_q;
  // triple products, others carried along
  logic signed [TW-1:0] t01_q, t02_q, t11_q, t12_q;
  logic signed [TW-1:0] cycp_b_q, sycp_b_q, sycr_b_q, sysr_b_q;
  logic signed [TW-1:0] cycr_b_q, cysr_b_q, cpsr_b_q, cpcr_b_q;
  logic signed [SW-1:0] msp_b_q;
  ezyx_out_t            mat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cysp_q <= mul30(cy_i, sp_i);
      sysp_q <= mul30(sy_i, sp_i);
      cycp_q <= mul30(cy_i, cp_i);
      sycp_q <= mul30(sy_i, cp_i);
      sycr_q <= mul30(sy_i, cr_i);
      sysr_q <= mul30(sy_i, sr_i);
      cycr_q <= mul30(cy_i, cr_i);
      cysr_q <= mul30(cy_i, sr_i);
      cpsr_q <= mul30(cp_i, sr_i);
      cpcr_q <= mul30(cp_i, cr_i);
      sr_q   <= sr_i;
      cr_q   <= cr_i;
      msp_q  <= -SW'(sp_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t01_q    <= mul30(cysp_q, sr_q);
      t02_q    <= mul30(cysp_q, cr_q);
      t11_q    <= mul30(sysp_q, sr_q);
      t12_q    <= mul30(sysp_q, cr_q);
      cycp_b_q <= cycp_q;
      sycp_b_q <= sycp_q;
      sycr_b_q <= sycr_q;
      sysr_b_q <= sysr_q;
      cycr_b_q <= cycr_q;
      cysr_b_q <= cysr_q;
      cpsr_b_q <= cpsr_q;
      cpcr_b_q <= cpcr_q;
      msp_b_q  <= msp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q.elem_00 <= to_elem(SW'(cycp_b_q));
      mat_q.elem_01 <= to_elem(SW'(t01_q) - SW'(sycr_b_q));
      mat_q.elem_02 <= to_elem(SW'(t02_q) + SW'(sysr_b_q));
      mat_q.elem_10 <= to_elem(SW'(sycp_b_q));
      mat_q.elem_11 <= to_elem(SW'(t11_q) + SW'(cycr_b_q));
      mat_q.elem_12 <= to_elem(SW'(t12_q) - SW'(cysr_b_q));
      mat_q.elem_20 <= to_elem(msp_b_q);
      mat_q.elem_21 <= to_elem(SW'(cpsr_b_q));
      mat_q.elem_22 <= to_elem(SW'(cpcr_b_q));
    end
  end

  assign mat_o = mat_q;

endmodule

// ----- rtl/euler_zyx_rotation_matrix.sv -----
// Euler ZYX rotation matrix: R = Rz(yaw) * Ry(pitch) * Rx(roll).
// Input channel : in_valid_i / in_stall_o, item = three angles in Q2.13 rad.
// Output channel: out_valid_o / out_stall_i, item = nine elements in Q1.14,
//   clipped to +/-1.0.
// An item is taken on a clock edge with valid high and stall low.
// Throughput: one item per cycle, sustained while the output is not stalled.
// Pipeline: reduction stage, one CORDIC stage per iteration,
//   sine/cosine register, then three product/sum stages.
// The depth is set by the CORDIC pipeline; the widest step is one 32x32
//   multiply with rounding.
// A stall at the output while an item is held there freezes every stage at
//   once; in_stall_o rises in the same cycle, so nothing is dropped or
//   repeated. The output register holds its item until it is taken.
// Reset clears all valid bits; the datapath registers are not reset.
module euler_zyx_rotation_matrix #(
  parameter int unsigned TRIG_STAGES = ezyx_pkg::TRIG_STAGES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ezyx_pkg::ezyx_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ezyx_pkg::ezyx_out_t  out_data_o
);
  import ezyx_pkg::*;

  localparam int unsigned Lat = TRIG_STAGES + 5;

  logic                 en;
  logic [Lat-1:0]       vld_q;
  logic signed [TW-1:0] sr, cr, sp, cp, sy, cy;

  // global advance: whole pipe moves unless the output item is held
  assign en         = !(vld_q[Lat-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  ezyx_trig #(.TRIG_STAGES(TRIG_STAGES)) u_roll (
    .clk_i, .en_i(en), .angle_i(in_data_i.roll_angle), .sin_o(sr), .cos_o(cr)
  );
  ezyx_trig #(.TRIG_STAGES(TRIG_STAGES)) u_pitch (
    .clk_i, .en_i(en), .angle_i(in_data_i.pitch_angle), .sin_o(sp), .cos_o(cp)
  );
  ezyx_trig #(.TRIG_STAGES(TRIG_STAGES)) u_yaw (
    .clk_i, .en_i(en), .angle_i(in_data_i.yaw_angle), .sin_o(sy), .cos_o(cy)
  );

  ezyx_matrix u_matrix (
    .clk_i, .en_i(en),
    .sr_i(sr), .cr_i(cr), .sp_i(sp), .cp_i(cp), .sy_i(sy), .cy_i(cy),
    .mat_o(out_data_o)
  );

  assign out_valid_o = vld_q[Lat-1];

endmodule

// ----- rtl/ezyx_checker.sv -----
module ezyx_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ezyx_pkg::ezyx_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ezyx_pkg::ezyx_out_t out_data_o
);
  import ezyx_pkg::*;

  // input backpressure only ever comes from a held output item
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // an offered input item carries known angles
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_data_i))
    else $error("input item with unknown angles");

  // elements 00 and 20 stay within +/-1.0
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.elem_00) <= 16384
                  && $signed(out_data_o.elem_00) >= -16384
                  && $signed(out_data_o.elem_20) <= 16384
                  && $signed(out_data_o.elem_20) >= -16384))
    else $error("matrix element out of range");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output item dropped under stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("output item changed under stall");

endmodule

bind euler_zyx_rotation_matrix ezyx_checker u_ezyx_checker (.*);
